@@ design/dtfx_pkg.sv @@
package dtfx_pkg;

  // Default number of fraction digits that are accumulated
  localparam int FRAC_DIGITS_DEF = 10;
  localparam int FRAC_DIGITS_MAX = 15;

  localparam int INT_W  = 31;
  localparam int FRAC_W = 33;
  localparam int VAL_W  = 64;

  localparam logic [INT_W-1:0] INT_MAX = {INT_W{1'b1}};

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_SPACE = 3'd0,
    PH_SIGN  = 3'd1,
    PH_INT   = 3'd2,
    PH_FRAC  = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  // Parsed number handed from the parser to the output stage
  typedef struct packed {
    logic              negative;
    logic              saturated;
    logic [INT_W-1:0]  integer_acc;
    logic [FRAC_W-1:0] fraction_acc;
  } snap_t;

  // round(2^32 / 10^(k+1)) for fraction digit position k
  function automatic logic [31:0] frac_weight(input logic [3:0] k);
    logic [31:0] w;
    case (k)
      4'd0:    w = 32'd429496730;
      4'd1:    w = 32'd42949673;
      4'd2:    w = 32'd4294967;
      4'd3:    w = 32'd429497;
      4'd4:    w = 32'd42950;
      4'd5:    w = 32'd4295;
      4'd6:    w = 32'd429;
      4'd7:    w = 32'd43;
      4'd8:    w = 32'd4;
      default: w = 32'd0;
    endcase
    return w;
  endfunction

endpackage

@@ design/dtfx_if.sv @@
interface dtfx_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface dtfx_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic               overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink   (input valid, input value, input overflow, output ready);
endinterface

@@ design/dtfx_parse.sv @@
module dtfx_parse #(
  parameter int FRAC_DIGITS = dtfx_pkg::FRAC_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        char_code,
  input  logic              last,
  input  logic              take,
  output logic              snap_valid,
  output dtfx_pkg::snap_t   snap
);
  import dtfx_pkg::*;

  localparam int CNT_W = $clog2(FRAC_DIGITS + 1);

  phase_t            phase, phase_next;
  logic              negative, negative_next;
  logic [INT_W-1:0]  integer_acc, integer_acc_next;
  logic [FRAC_W-1:0] fraction_acc, fraction_acc_next;
  logic [CNT_W-1:0]  fraction_count, fraction_count_next;
  logic              saturated, saturated_next;

  logic              is_digit;
  logic              is_space;
  logic [3:0]        digit;
  logic [INT_W+3:0]  int_prod;
  logic [35:0]       frac_add;
  logic              consumed;

  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_space = ((char_code >= CH_TAB) && (char_code <= CH_CR)) || (char_code == CH_SPACE);
  assign digit    = 4'(char_code - CH_ZERO);
  assign int_prod = {integer_acc, 3'b000} + {2'b00, integer_acc, 1'b0}
                  + {{INT_W{1'b0}}, digit};
  assign frac_add = 36'(digit) * 36'(frac_weight(4'(fraction_count)));

  // Fall through the phases the way one character may cross several of them
  always_comb begin
    phase_next          = phase;
    negative_next       = negative;
    integer_acc_next    = integer_acc;
    fraction_acc_next   = fraction_acc;
    fraction_count_next = fraction_count;
    saturated_next      = saturated;
    consumed            = 1'b0;

    if (phase_next == PH_SPACE) begin
      if (is_space) begin
        consumed = 1'b1;
      end else begin
        phase_next = PH_SIGN;
      end
    end
    if (!consumed && phase_next == PH_SIGN) begin
      if (char_code == CH_MINUS) begin
        negative_next = ~negative;
        consumed      = 1'b1;
      end else if (char_code == CH_PLUS) begin
        consumed = 1'b1;
      end else begin
        phase_next = PH_INT;
      end
    end
    if (!consumed && phase_next == PH_INT) begin
      consumed = 1'b1;
      if (is_digit) begin
        if (int_prod > {4'b0000, INT_MAX}) begin
          integer_acc_next = INT_MAX;
          saturated_next   = 1'b1;
        end else begin
          integer_acc_next = int_prod[INT_W-1:0];
        end
      end else if (char_code == CH_POINT) begin
        phase_next = PH_FRAC;
      end else begin
        phase_next = PH_DONE;
      end
    end else if (!consumed && phase_next == PH_FRAC) begin
      if (is_digit) begin
        if (fraction_count < CNT_W'(FRAC_DIGITS)) begin
          fraction_acc_next   = fraction_acc + frac_add[FRAC_W-1:0];
          fraction_count_next = fraction_count + 1'b1;
        end
      end else begin
        phase_next = PH_DONE;
      end
    end
  end

  // Advance on each processed character; return to the idle string on last
  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      phase          <= PH_SPACE;
      negative       <= 1'b0;
      integer_acc    <= '0;
      fraction_acc   <= '0;
      fraction_count <= '0;
      saturated      <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      negative       <= negative_next;
      integer_acc    <= integer_acc_next;
      fraction_acc   <= fraction_acc_next;
      fraction_count <= fraction_count_next;
      saturated      <= saturated_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (step && last) begin
      snap_valid <= 1'b1;
    end else if (take) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && last) begin
      snap.negative     <= negative_next;
      snap.saturated    <= saturated_next;
      snap.integer_acc  <= integer_acc_next;
      snap.fraction_acc <= fraction_acc_next;
    end
  end

endmodule

@@ design/dtfx_format.sv @@
module dtfx_format (
  input  logic            clk,
  input  logic            rst,
  input  logic            snap_valid,
  input  dtfx_pkg::snap_t snap,
  output logic            take,
  dtfx_result_if.source   result
);
  import dtfx_pkg::*;

  logic [31:0]      upper;
  logic [VAL_W-1:0] mag;
  logic [VAL_W-1:0] signed_val;

  // Fraction carry folds into the integer half
  assign upper      = {1'b0, snap.integer_acc} + 32'(snap.fraction_acc[FRAC_W-1]);
  assign mag        = {upper, snap.fraction_acc[31:0]};
  assign signed_val = snap.negative ? (~mag + 1'b1) : mag;

  assign take = snap_valid && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.value    <= signed_val;
      result.overflow <= snap.saturated;
    end
  end

endmodule

@@ design/decimal_text_to_fixed_point.sv @@
// Result path: a taken last beat's number goes to the snapshot, then the result register.
// Throughput: one character beat per cycle unless a last beat waits for snapshot room.
// Input register, parse stage and output register each stall only when the next is full.
// Reset (rst, synchronous, active high) empties all stages and returns the parser
// to the leading white space phase with all accumulators cleared.
module decimal_text_to_fixed_point #(
  parameter int FRAC_DIGITS = dtfx_pkg::FRAC_DIGITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  dtfx_char_if.sink     chars,
  dtfx_result_if.source result
);
  import dtfx_pkg::*;

  // Input register: hold one character beat
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;

  // Handshake between parse and format stages
  logic  snap_valid;
  logic  take;
  snap_t snap;
  logic  snap_free;
  logic  step;

  // A non-final character never waits; a final one needs room for its number
  assign snap_free   = !snap_valid || take;
  assign step        = in_valid && (!in_last || snap_free);
  assign chars.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_char <= chars.char_code;
      in_last <= chars.last;
    end
  end

  // Parse stage: advance the character state machine, capture the number on last
  dtfx_parse #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_code (in_char),
    .last      (in_last),
    .take      (take),
    .snap_valid(snap_valid),
    .snap      (snap)
  );

  // Output stage: combine halves, apply sign, register the result beat
  dtfx_format u_format (
    .clk       (clk),
    .rst       (rst),
    .snap_valid(snap_valid),
    .snap      (snap),
    .take      (take),
    .result    (result)
  );

endmodule

@@ tb/decimal_text_to_fixed_point_tb.sv @@
`timescale 1ns / 1ps

module decimal_text_to_fixed_point_tb;
  import dtfx_pkg::*;

  localparam int FRAC_LIMIT = FRAC_DIGITS_DEF;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int DIR_N = 34;

  // Character codes used by the stimulus beyond the package set
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TOP = 8'hFF;
  localparam logic [7:0] CH_LETTER_X = 8'h78;

  // One expected number, as it should appear on the result channel
  typedef struct packed {
    logic [63:0] value;
    logic        overflow;
  } parsed_t;

  // One directed character; known rows carry a hand-written expectation
  typedef struct packed {
    logic [7:0]  code;
    logic        last;
    logic        known;
    logic [63:0] value;
    logic        overflow;
  } dir_row_t;

  logic clk;
  logic rst;

  dtfx_char_if   chars_if ();
  dtfx_result_if result_if ();

  decimal_text_to_fixed_point #(
    .FRAC_DIGITS(FRAC_LIMIT)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars_if.sink),
    .result(result_if.source)
  );

  // Parser shadow state, advanced once per accepted character beat
  phase_t            parse_phase;
  logic              parse_neg;
  logic [INT_W-1:0]  int_acc;
  logic [FRAC_W-1:0] frac_acc;
  logic [3:0]        frac_cnt;
  logic              int_sat;

  parsed_t pending_numbers [$];
  parsed_t want;
  logic [7:0] text_q [$];
  dir_row_t dir_rows [DIR_N];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int cycle_count;
  int hold_reqs;
  int hold_seen;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Weight of fraction digit position pos (0-based): round(2^32 / 10^(pos+1))
  function automatic logic [31:0] frac_step(input int pos);
    longint unsigned scale;
    scale = 1;
    repeat (pos + 1) scale = scale * 10;
    return 32'(((64'd1 << 33) + scale) / (2 * scale));
  endfunction

  task automatic clear_parser();
    parse_phase = PH_SPACE;
    parse_neg   = 1'b0;
    int_acc     = '0;
    frac_acc    = '0;
    frac_cnt    = '0;
    int_sat     = 1'b0;
  endtask

  // Advance the shadow parser by one character. Phases fall through in
  // order, so a character that ends one phase is retried by the next.
  task automatic parse_char(input logic [7:0] c);
    logic [34:0] grown;
    logic        is_digit;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (parse_phase == PH_SPACE) begin
      if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) return;
      parse_phase = PH_SIGN;
    end
    if (parse_phase == PH_SIGN) begin
      if (c == CH_MINUS) begin
        parse_neg = ~parse_neg;
        return;
      end
      if (c == CH_PLUS) return;
      parse_phase = PH_INT;
    end
    if (parse_phase == PH_INT) begin
      if (is_digit) begin
        grown = 35'(int_acc) * 35'd10 + 35'(c - CH_ZERO);
        // Saturate at the largest integer part and remember it
        if (grown > 35'(INT_MAX)) begin
          int_acc = INT_MAX;
          int_sat = 1'b1;
        end else begin
          int_acc = grown[INT_W-1:0];
        end
      end else if (c == CH_POINT) begin
        parse_phase = PH_FRAC;
      end else begin
        parse_phase = PH_DONE;
      end
      return;
    end
    if (parse_phase == PH_FRAC) begin
      if (is_digit) begin
        // Digits past the configured count are swallowed without weight
        if (frac_cnt < FRAC_LIMIT && frac_cnt < FRAC_DIGITS_MAX) begin
          frac_acc = frac_acc + FRAC_W'(64'(c - CH_ZERO) * 64'(frac_step(frac_cnt)));
          frac_cnt = frac_cnt + 4'd1;
        end
      end else begin
        parse_phase = PH_DONE;
      end
      return;
    end
    parse_phase = PH_DONE;
  endtask

  // Offer one character beat, hold it until taken, then advance the shadow
  // parser. On the final beat queue the number it should produce: the typed
  // value where the row has one, else the shadow parser's result.
  task automatic send_char(input logic [7:0] code, input logic fin, input logic known,
                           input logic [63:0] known_value, input logic known_ovf);
    logic [63:0] mag;
    parsed_t     num;
    while ($urandom_range(99) < send_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.char_code <= code;
    chars_if.last      <= fin;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    parse_char(code);
    if (fin) begin
      mag = {int_acc, 32'd0} + 64'(frac_acc);
      if (parse_neg) mag = -mag;
      num.value    = known ? known_value : mag;
      num.overflow = known ? known_ovf : int_sat;
      pending_numbers.push_back(num);
      clear_parser();
    end
  endtask

  // Build one random number string into text_q. Most are well formed with
  // random content; the rest are raw byte noise. Trailing junk exercises the
  // done phase, where everything up to the final beat is ignored.
  task automatic make_number_text();
    int    n;
    int    shape;
    string near_max;
    near_max = "21474836";
    text_q.delete();
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) text_q.push_back(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(0, 2);
      repeat (n)
        text_q.push_back(($urandom_range(5) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(4)));
      n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) text_q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
      shape = $urandom_range(7);
      if (shape == 0) begin
        // Walk right up to the saturation boundary
        foreach (near_max[i]) text_q.push_back(8'(near_max[i]));
        n = 2;
      end else if (shape == 1) begin
        n = $urandom_range(10, 11);
      end else begin
        n = $urandom_range(0, 4);
      end
      repeat (n) text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(3) != 0) begin
        text_q.push_back(CH_POINT);
        n = $urandom_range(0, 12);
        repeat (n) text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
      end
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) text_q.push_back(8'($urandom_range(255)));
      end
    end
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic run_random(input int n_chars);
    int sent;
    sent = 0;
    while (sent < n_chars) begin
      make_number_text();
      foreach (text_q[i])
        send_char(text_q[i], i == text_q.size() - 1, 1'b0, 64'd0, 1'b0);
      sent += text_q.size();
    end
  endtask

  // Result side: check each taken beat against the oldest queued number,
  // then pick ready for the next cycle. A pressure request loads a long
  // hold-off that this process counts down on its own.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        if (pending_numbers.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: value=%h overflow=%b",
                     result_if.value, result_if.overflow);
        end else begin
          want = pending_numbers.pop_front();
          if (result_if.value !== want.value || result_if.overflow !== want.overflow) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected value=%h overflow=%b, got value=%h overflow=%b",
                       want.value, want.overflow, result_if.value, result_if.overflow);
          end
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    // Drive every input known from time zero and hold reset
    rst                = 1'b1;
    chars_if.valid     = 1'b0;
    chars_if.char_code = CH_NUL;
    chars_if.last      = 1'b0;
    result_if.ready    = 1'b0;
    fail_count         = 0;
    cycle_count        = 0;
    hold_reqs          = 0;
    hold_seen          = 0;
    hold_left          = 0;
    send_idle_pct      = 32;
    recv_idle_pct      = 62;
    clear_parser();

    // Directed strings, one row per character beat:
    //   lone NUL and lone 0xFF: empty numbers
    //   CR, tab, space, '+', '-', '0': white space extremes and negative zero
    //   "-.5x": point with no integer digits, then a stray letter
    //   "3000000000": integer part saturates
    //   ".99999999999": one fraction digit more than is accumulated
    dir_rows = '{
      '{CH_NUL,      1'b1, 1'b1, 64'd0, 1'b0},
      '{CH_TOP,      1'b1, 1'b1, 64'd0, 1'b0},
      '{CH_CR,       1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_TAB,      1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_SPACE,    1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_PLUS,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_MINUS,    1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_ZERO,     1'b1, 1'b1, 64'd0, 1'b0},
      '{CH_MINUS,    1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_POINT,    1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_ZERO + 8'd5, 1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_LETTER_X, 1'b1, 1'b0, 64'd0, 1'b0},
      '{CH_ZERO + 8'd3, 1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_ZERO,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_ZERO,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_ZERO,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_ZERO,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_ZERO,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_ZERO,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_ZERO,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_ZERO,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_ZERO,     1'b1, 1'b1, 64'h7FFF_FFFF_0000_0000, 1'b1},
      '{CH_POINT,    1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,     1'b0, 1'b0, 64'd0, 1'b0},
      '{CH_NINE,     1'b1, 1'b0, 64'd0, 1'b0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_char(dir_rows[i].code, dir_rows[i].last, dir_rows[i].known,
                dir_rows[i].value, dir_rows[i].overflow);

    // Random strings: sender sparse and receiver sparser, then swapped
    run_random(140);
    send_idle_pct = 62;
    recv_idle_pct = 32;
    run_random(140);

    // Full rate on both sides; open with a long receiver hold-off so the
    // pipeline backs up and the character channel stalls
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_reqs++;
    run_random(140);

    // Drop valid, drain, then allow a few more cycles for stray beats
    chars_if.valid <= 1'b0;
    while (pending_numbers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_numbers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/dtfx_pkg.sv
design/dtfx_if.sv
design/dtfx_parse.sv
design/dtfx_format.sv
design/decimal_text_to_fixed_point.sv
tb/decimal_text_to_fixed_point_tb.sv
